FILE: hw/rtl/uihg_pkg.sv
// shared types, constants and checksum helper for the udp/ipv4 header generator
`timescale 1ns / 1ps

package uihg_pkg;

  localparam int unsigned MaxPayload = 1472;
  localparam int unsigned CountW     = 11;
  localparam int unsigned HdrBytes   = 28;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned CsumSteps  = 10;
  localparam int unsigned StepW      = 4;

  localparam logic [CountW-1:0] MAX_COUNT  = CountW'(MaxPayload);
  localparam logic [IdxW-1:0]   LAST_INDEX = IdxW'(HdrBytes - 1);
  localparam logic [StepW-1:0]  LAST_STEP  = StepW'(CsumSteps);

  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [7:0]  TTL_VALUE   = 8'd64;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] IP_UDP_HLEN = 16'd28;
  localparam logic [15:0] UDP_HLEN    = 16'd8;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_IP   = 3'd0;
  localparam logic [2:0] REG_DEST_IP     = 3'd1;
  localparam logic [2:0] REG_SOURCE_PORT = 3'd2;
  localparam logic [2:0] REG_DEST_PORT   = 3'd3;

  typedef struct packed {
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // datagram summary handed from the accumulator to the header unit
  typedef struct packed {
    logic              start;
    logic [15:0]       sum;
    logic [7:0]        pend;
    logic              odd;
    logic [CountW-1:0] count;
    logic              ovf;
  } snap_t;

  // ones-complement add with full carry fold
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    begin
      s = {1'b0, acc} + {1'b0, word};
      s = {1'b0, s[15:0]} + {16'b0, s[16]};
      s = {1'b0, s[15:0]} + {16'b0, s[16]};
      oc_add = s[15:0];
    end
  endfunction

endpackage

FILE: hw/rtl/uihg_acc.sv
// payload accumulator: running sum, odd byte, byte count and overflow flag
`timescale 1ns / 1ps

module uihg_acc import uihg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  output snap_t       snap
);

  logic [15:0]       running_sum, running_sum_next;
  logic [CountW-1:0] payload_count, payload_count_next;
  logic [7:0]        pending_high_byte, pending_high_byte_next;
  logic              odd_phase, odd_phase_next;
  logic              overflow_seen, overflow_seen_next;

  always_comb begin
    running_sum_next       = running_sum;
    payload_count_next     = payload_count;
    pending_high_byte_next = pending_high_byte;
    odd_phase_next         = odd_phase;
    overflow_seen_next     = overflow_seen;
    if (payload_count < MAX_COUNT) begin
      if (!odd_phase) begin
        pending_high_byte_next = payload_byte;
        odd_phase_next         = 1'b1;
      end else begin
        running_sum_next = oc_add(running_sum, {pending_high_byte, payload_byte});
        odd_phase_next   = 1'b0;
      end
      payload_count_next = payload_count + 1'b1;
    end else begin
      overflow_seen_next = 1'b1;
    end
  end

  always_comb begin
    snap.start = accept & last_byte;
    snap.sum   = running_sum_next;
    snap.pend  = pending_high_byte_next;
    snap.odd   = odd_phase_next;
    snap.count = payload_count_next;
    snap.ovf   = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      running_sum       <= '0;
      payload_count     <= '0;
      pending_high_byte <= '0;
      odd_phase         <= 1'b0;
      overflow_seen     <= 1'b0;
    end else if (accept) begin
      running_sum       <= running_sum_next;
      payload_count     <= payload_count_next;
      pending_high_byte <= pending_high_byte_next;
      odd_phase         <= odd_phase_next;
      overflow_seen     <= overflow_seen_next;
    end
  end

endmodule

FILE: hw/rtl/uihg_hdr.sv
// header unit: serial checksum finish and 28-byte header output register
`timescale 1ns / 1ps

module uihg_hdr import uihg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  snap_t           snap,
  input  cfg_t            cfg,
  input  logic            header_stall,
  output logic            header_valid,
  output logic [7:0]      header_byte,
  output logic [IdxW-1:0] header_index,
  output logic            header_done,
  output logic            oversize
);

  logic [7:0]        pend;
  logic              odd;
  logic [CountW-1:0] count;
  logic              ovf;
  logic [15:0]       csum, csum_next;
  logic [StepW-1:0]  step;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx_next;
  logic [15:0]       udp_len, tot_len, check;
  logic [15:0]       word;
  logic [7:0]        byte_next;

  assign udp_len = UDP_HLEN + {{(16-CountW){1'b0}}, count};
  assign tot_len = IP_UDP_HLEN + {{(16-CountW){1'b0}}, count};
  // zero checksum goes out as all ones
  assign check   = (~csum == 16'h0000) ? 16'hFFFF : ~csum;

  always_comb begin
    case (step)
      4'd0:    word = odd ? {pend, 8'h00} : 16'h0000;
      4'd1:    word = cfg.source_ip[31:16];
      4'd2:    word = cfg.source_ip[15:0];
      4'd3:    word = cfg.dest_ip[31:16];
      4'd4:    word = cfg.dest_ip[15:0];
      4'd5:    word = {8'h00, PROTO_UDP};
      4'd6:    word = udp_len;
      4'd7:    word = cfg.source_port;
      4'd8:    word = cfg.dest_port;
      4'd9:    word = udp_len;
      default: word = 16'h0000;
    endcase
    csum_next = oc_add(csum, word);
  end

  assign idx_next = idx + 1'b1;

  always_comb begin
    case (idx_next)
      5'd0:    byte_next = VER_IHL;
      5'd2:    byte_next = tot_len[15:8];
      5'd3:    byte_next = tot_len[7:0];
      5'd8:    byte_next = TTL_VALUE;
      5'd9:    byte_next = PROTO_UDP;
      5'd12:   byte_next = cfg.source_ip[31:24];
      5'd13:   byte_next = cfg.source_ip[23:16];
      5'd14:   byte_next = cfg.source_ip[15:8];
      5'd15:   byte_next = cfg.source_ip[7:0];
      5'd16:   byte_next = cfg.dest_ip[31:24];
      5'd17:   byte_next = cfg.dest_ip[23:16];
      5'd18:   byte_next = cfg.dest_ip[15:8];
      5'd19:   byte_next = cfg.dest_ip[7:0];
      5'd20:   byte_next = cfg.source_port[15:8];
      5'd21:   byte_next = cfg.source_port[7:0];
      5'd22:   byte_next = cfg.dest_port[15:8];
      5'd23:   byte_next = cfg.dest_port[7:0];
      5'd24:   byte_next = udp_len[15:8];
      5'd25:   byte_next = udp_len[7:0];
      5'd26:   byte_next = check[15:8];
      5'd27:   byte_next = check[7:0];
      default: byte_next = 8'h00;
    endcase
  end

  // snapshot and checksum steps; steps finish long before byte 26 is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= LAST_STEP;
    end else if (snap.start) begin
      step <= '0;
    end else if (step != LAST_STEP) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.start) begin
      pend  <= snap.pend;
      odd   <= snap.odd;
      count <= snap.count;
      ovf   <= snap.ovf;
      csum  <= snap.sum;
    end else if (step != LAST_STEP) begin
      csum <= csum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_valid <= 1'b0;
    end else if (snap.start) begin
      header_valid <= 1'b1;
    end else if (header_valid && !header_stall && idx == LAST_INDEX) begin
      header_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.start) begin
      idx         <= '0;
      header_byte <= VER_IHL;
    end else if (header_valid && !header_stall && idx != LAST_INDEX) begin
      idx         <= idx_next;
      header_byte <= byte_next;
    end
  end

  assign header_index = idx;
  assign header_done  = (idx == LAST_INDEX);
  assign oversize     = ovf;

endmodule

FILE: hw/rtl/udp_ipv4_header_generator.sv
// top level of the udp/ipv4 header generator: config registers and unit wiring
//
//   channel   direction  handshake                   fields
//   payload   in         payload_valid/stall         payload_byte, last_byte
//   header    out        header_valid/stall          header_byte, header_index,
//                                                    header_done, oversize
//   config    in         cfg_wr_en                   cfg_index, cfg_data
//
// one payload byte per cycle while payload_stall is low; the running sum is updated in
// the cycle the byte is taken; the byte marked last starts a 28-byte header burst,
// one byte per cycle with no stall; payload_stall stays high for the whole burst
// the checksum is finished in steps by a single ones-complement adder during the burst
// reset clears datagram state and registers; a stalled header byte holds
`timescale 1ns / 1ps

module udp_ipv4_header_generator import uihg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        payload_valid,
  output logic        payload_stall,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  output logic        header_valid,
  input  logic        header_stall,
  output logic [7:0]  header_byte,
  output logic [4:0]  header_index,
  output logic        header_done,
  output logic        oversize,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  snap_t snap;
  logic  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SOURCE_IP:   cfg.source_ip   <= cfg_data;
        REG_DEST_IP:     cfg.dest_ip     <= cfg_data;
        REG_SOURCE_PORT: cfg.source_port <= cfg_data[15:0];
        REG_DEST_PORT:   cfg.dest_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign payload_stall = header_valid;
  assign accept        = payload_valid & ~payload_stall;

  uihg_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .snap         (snap)
  );

  uihg_hdr u_hdr (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .cfg          (cfg),
    .header_stall (header_stall),
    .header_valid (header_valid),
    .header_byte  (header_byte),
    .header_index (header_index),
    .header_done  (header_done),
    .oversize     (oversize)
  );

endmodule

FILE: hw/rtl/uihg_checker.sv
// port-level checker for the udp/ipv4 header generator, with its bind
`timescale 1ns / 1ps

module uihg_checker import uihg_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       payload_valid,
  input logic       payload_stall,
  input logic       last_byte,
  input logic       header_valid,
  input logic       header_stall,
  input logic [7:0] header_byte,
  input logic [4:0] header_index,
  input logic       header_done
);

  // last item starts a burst at byte 0
  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    payload_valid && !payload_stall && last_byte |=>
      header_valid && header_index == 5'd0 && header_byte == VER_IHL)
    else $error("header burst did not start at byte 0");

  // taken bytes advance the index by one until the end
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    header_valid && !header_stall && header_index != LAST_INDEX |=>
      header_valid && header_index == $past(header_index) + 5'd1)
    else $error("header index did not advance by one");

  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    header_valid |-> header_done == (header_index == LAST_INDEX))
    else $error("header_done does not match the final index");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    header_valid && header_stall |=>
      header_valid && $stable(header_byte) && $stable(header_index))
    else $error("stalled header item changed");

endmodule

bind udp_ipv4_header_generator uihg_checker u_uihg_checker (
  .clk           (clk),
  .rst           (rst),
  .payload_valid (payload_valid),
  .payload_stall (payload_stall),
  .last_byte     (last_byte),
  .header_valid  (header_valid),
  .header_stall  (header_stall),
  .header_byte   (header_byte),
  .header_index  (header_index),
  .header_done   (header_done)
);

FILE: tb/udp_ipv4_header_generator_test.sv
// self-checking testbench for the udp/ipv4 header generator
`timescale 1ns / 1ps

module udp_ipv4_header_generator_test import uihg_pkg::*; ();

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          DRAIN_CYCLES = HdrBytes + CsumSteps + 4;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RANDOM_ITEMS = 200;
  localparam logic [2:0]  REG_FIRST_UNUSED = REG_DEST_PORT + 3'd1;
  localparam logic [2:0]  REG_INDEX_TOP    = '1;

  // mirror of the block: running sum, config and the header bytes still owed
  class header_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic [4:0] index;
      logic       done;
      logic       ovf;
    } hdr_entry_t;

    cfg_t              regs;
    logic [15:0]       word_sum;
    logic [CountW-1:0] byte_count;
    logic [7:0]        high_byte;
    logic              odd;
    logic              dropped;
    hdr_entry_t        header_bytes_due[$];
    int                errors;

    function new();
      regs = '0;
      errors = 0;
      restart_datagram();
    endfunction

    function void restart_datagram();
      word_sum = '0;
      byte_count = '0;
      high_byte = '0;
      odd = 1'b0;
      dropped = 1'b0;
    endfunction

    // end-around carry add; one fold is enough for two 16-bit terms
    static function logic [15:0] add16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + 16'(s[16]);
    endfunction

    // pseudo header plus udp header words (checksum field as zero)
    function logic [15:0] header_sum(logic [15:0] udp_len);
      logic [15:0] s;
      s = add16(regs.source_ip[31:16], regs.source_ip[15:0]);
      s = add16(s, regs.dest_ip[31:16]);
      s = add16(s, regs.dest_ip[15:0]);
      s = add16(s, 16'(PROTO_UDP));
      s = add16(s, udp_len);
      s = add16(s, udp_len);
      s = add16(s, regs.source_port);
      s = add16(s, regs.dest_port);
      return s;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SOURCE_IP: begin
          regs.source_ip = data;
        end
        REG_DEST_IP: begin
          regs.dest_ip = data;
        end
        REG_SOURCE_PORT: begin
          regs.source_port = data[15:0];
        end
        REG_DEST_PORT: begin
          regs.dest_port = data[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int outstanding();
      return header_bytes_due.size();
    endfunction

    function void take_payload_byte(logic [7:0] b, logic last);
      logic [15:0] udp_len;
      logic [15:0] total_len;
      logic [15:0] sum;
      logic [15:0] csum;
      logic [7:0]  hdr [HdrBytes];
      hdr_entry_t  e;
      if (byte_count < MAX_COUNT) begin
        if (odd) begin
          word_sum = add16(word_sum, {high_byte, b});
        end else begin
          high_byte = b;
        end
        odd = !odd;
        byte_count++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      udp_len = UDP_HLEN + 16'(byte_count);
      total_len = IP_UDP_HLEN + 16'(byte_count);
      // odd trailing byte pads with a zero low byte
      sum = odd ? add16(word_sum, {high_byte, 8'h00}) : word_sum;
      sum = add16(sum, header_sum(udp_len));
      csum = ~sum;
      if (csum == 16'h0000) csum = 16'hffff;
      foreach (hdr[k]) hdr[k] = 8'h00;
      hdr[0]  = VER_IHL;
      hdr[2]  = total_len[15:8];
      hdr[3]  = total_len[7:0];
      hdr[8]  = TTL_VALUE;
      hdr[9]  = PROTO_UDP;
      hdr[12] = regs.source_ip[31:24];
      hdr[13] = regs.source_ip[23:16];
      hdr[14] = regs.source_ip[15:8];
      hdr[15] = regs.source_ip[7:0];
      hdr[16] = regs.dest_ip[31:24];
      hdr[17] = regs.dest_ip[23:16];
      hdr[18] = regs.dest_ip[15:8];
      hdr[19] = regs.dest_ip[7:0];
      hdr[20] = regs.source_port[15:8];
      hdr[21] = regs.source_port[7:0];
      hdr[22] = regs.dest_port[15:8];
      hdr[23] = regs.dest_port[7:0];
      hdr[24] = udp_len[15:8];
      hdr[25] = udp_len[7:0];
      hdr[26] = csum[15:8];
      hdr[27] = csum[7:0];
      for (int k = 0; k < HdrBytes; k++) begin
        e.data = hdr[k];
        e.index = IdxW'(k);
        e.done = (e.index == LAST_INDEX);
        e.ovf = dropped;
        header_bytes_due.push_back(e);
      end
      restart_datagram();
    endfunction

    function void check_header(logic [7:0] data, logic [4:0] index, logic done, logic ovf);
      hdr_entry_t e;
      if (header_bytes_due.size() == 0) begin
        $error("header byte at index %0d arrived with nothing expected", index);
        errors++;
        return;
      end
      e = header_bytes_due.pop_front();
      if (data !== e.data) begin
        $error("header_byte: expected %02h, got %02h", e.data, data);
        errors++;
      end
      if (index !== e.index) begin
        $error("header_index: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (done !== e.done) begin
        $error("header_done: expected %0b, got %0b", e.done, done);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("oversize: expected %0b, got %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        payload_valid;
  logic        payload_stall;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        header_valid;
  logic        header_stall;
  logic [7:0]  header_byte;
  logic [4:0]  header_index;
  logic        header_done;
  logic        oversize;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  header_scoreboard sb;
  int cycles = 0;
  bit hold_req = 1'b0;

  udp_ipv4_header_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .payload_valid (payload_valid),
    .payload_stall (payload_stall),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .header_valid  (header_valid),
    .header_stall  (header_stall),
    .header_byte   (header_byte),
    .header_index  (header_index),
    .header_done   (header_done),
    .oversize      (oversize),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly no gap, some short, a few long; quiet windows with no gaps at all
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycles[10:9] == 2'b00) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] random_reg();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    payload_valid <= 1'b1;
    payload_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (payload_stall) @(posedge clk);
    sb.take_payload_byte(b, last);
    gap = pick_gap();
    if (gap != 0) begin
      payload_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_datagram(input int len);
    for (int i = 0; i < len; i++) send_byte(random_byte(), i == len - 1);
  endtask

  // two-byte payload whose word cancels the rest of the sum
  task automatic send_zero_checksum_datagram();
    logic [15:0] w;
    w = 16'hffff - sb.header_sum(UDP_HLEN + 16'd2);
    send_byte(w[15:8], 1'b0);
    send_byte(w[7:0], 1'b1);
  endtask

  task automatic wait_idle();
    payload_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [31:0] sip, input logic [31:0] dip,
                              input logic [31:0] sport, input logic [31:0] dport);
    write_reg(REG_SOURCE_IP, sip);
    write_reg(REG_DEST_IP, dip);
    write_reg(REG_SOURCE_PORT, sport);
    write_reg(REG_DEST_PORT, dport);
    // index past the register list must be ignored
    write_reg(3'($urandom_range(int'(REG_INDEX_TOP), int'(REG_FIRST_UNUSED))), $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_random();
    program_regs(random_reg(), random_reg(), random_reg(), random_reg());
  endtask

  // receiver side: random stalls, and one long hold when asked
  initial begin
    int g;
    header_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        header_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        g = pick_gap();
        header_stall <= (g != 0);
        repeat ((g == 0) ? 1 : g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && header_valid && !header_stall) begin
      sb.check_header(header_byte, header_index, header_done, oversize);
    end
  end

  initial begin
    int sent;
    int len;
    int datagrams;
    sb = new();
    rst <= 1'b1;
    payload_valid <= 1'b0;
    payload_byte <= 8'h00;
    last_byte <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SOURCE_IP;
    cfg_data <= 32'h0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset values
    send_byte(8'h00, 1'b1);
    wait_idle();
    program_regs('1, '1, '1, '1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_zero_checksum_datagram();
    wait_idle();
    program_regs('0, '0, '0, '0);
    send_zero_checksum_datagram();
    send_byte(8'hff, 1'b1);
    wait_idle();
    program_random();
    // fills the payload, then two bytes over it are dropped, the last one too
    send_random_datagram(MaxPayload + 2);

    sent = 0;
    datagrams = 0;
    hold_req = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (datagrams % 8 == 7) begin
        wait_idle();
        program_random();
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: len = $urandom_range(1, 4);
        10, 11, 12, 13, 14, 15, 16: len = $urandom_range(5, 16);
        17, 18: len = $urandom_range(17, 64);
        default: len = 1;
      endcase
      send_random_datagram(len);
      sent += len;
      datagrams++;
    end
    wait_idle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/uihg_pkg.sv
hw/rtl/uihg_acc.sv
hw/rtl/uihg_hdr.sv
hw/rtl/udp_ipv4_header_generator.sv
hw/rtl/uihg_checker.sv
tb/udp_ipv4_header_generator_test.sv
